// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked implication checks with active-low reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define ASSERT_SAME(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error(msg);
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error(msg);
`else
`define ASSERT_SAME(label, clk, rst_n, a, b, msg)
`define ASSERT_NEXT(label, clk, rst_n, a, b, msg)
`endif
`endif

// File: hw/rtl/fdrt_pkg.sv
// ----------------------------------------------------------------------------
// fdrt_pkg
// Shared widths, codes, reset values and types of the damage tracker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fdrt_pkg;

    localparam int ADDR_W   = 32;
    localparam int DIM_W    = 13;
    localparam int MAX_DIM  = 4096;
    localparam int CNT_W    = $clog2(ADDR_W);
    localparam int CFG_IDX_W = 3;
    localparam int REGION_W = 2;
    localparam int OUT_W    = 4 * DIM_W;
    localparam int OUT_BYTES_W = ((OUT_W + 7) / 8) * 8;

    // region codes
    localparam logic [REGION_W-1:0] REGION_RAM     = 2'd0;
    localparam logic [REGION_W-1:0] REGION_DISPLAY = 2'd1;
    localparam logic [REGION_W-1:0] REGION_IO      = 2'd2;
    localparam logic [REGION_W-1:0] REGION_QUERY   = 2'd3;

    // input opcodes
    localparam logic OP_STORE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_BASE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEMORY_LIMIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd3;

    // reset values
    localparam logic [ADDR_W-1:0] RST_DISPLAY_BASE = 32'd950016;
    localparam logic [ADDR_W-1:0] RST_MEMORY_LIMIT = 32'd1048576;
    localparam logic [DIM_W-1:0]  RST_FRAME_WIDTH  = 13'd32;
    localparam logic [DIM_W-1:0]  RST_FRAME_HEIGHT = 13'd768;

    // divider outcome handed to the sequencer
    typedef struct packed {
        logic              done;
        logic [ADDR_W-1:0] quotient;
        logic [DIM_W-1:0]  remainder;
    } t_div_result;

    // saturate a written dimension to 1..MAX_DIM
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] res;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (v > DIM_W'(MAX_DIM)) begin
            res = DIM_W'(MAX_DIM);
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

// File: hw/rtl/fdrt_divider.sv
// ----------------------------------------------------------------------------
// fdrt_divider
// Restoring divider, one quotient bit per cycle, for offset / frame width.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fdrt_divider
    import fdrt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [ADDR_W-1:0] i_dividend,
    input  logic [DIM_W-1:0]  i_divisor,
    output t_div_result       o_result
);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [ADDR_W-1:0] r_quo, n_quo;
    logic [DIM_W-1:0]  r_rem, n_rem;
    logic [DIM_W-1:0]  r_div, n_div;

    logic [DIM_W:0]    shifted;
    logic [DIM_W:0]    diff;
    logic              take;

    // one trial subtraction per cycle
    always_comb begin
        shifted = {r_rem, r_quo[ADDR_W-1]};
        diff    = shifted - {1'b0, r_div};
        take    = (shifted >= {1'b0, r_div});
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_div  = r_div;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(ADDR_W - 1);
            n_quo  = i_dividend;
            n_rem  = '0;
            n_div  = i_divisor;
        end else if (r_busy) begin
            n_quo = {r_quo[ADDR_W-2:0], take};
            n_rem = take ? diff[DIM_W-1:0] : shifted[DIM_W-1:0];
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_result.done      = r_done;
    assign o_result.quotient  = r_quo;
    assign o_result.remainder = r_rem;

endmodule

// File: hw/rtl/framebuffer_damage_rectangle_tracker.sv
// A RAM or I/O store and a query give their result item in the cycle after
// acceptance; a display store's result follows acceptance, the divider steps and the update.
// Items are taken one at a time: none while the bit-serial offset / width divider works.
// Reset (synchronous, active low) restores the register defaults and the empty
// rectangle; the configuration port is always ready.
// ----------------------------------------------------------------------------
// framebuffer_damage_rectangle_tracker
// Classifies store addresses, keeps the damaged rectangle of the display and answers queries, which clear it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module framebuffer_damage_rectangle_tracker
    import fdrt_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration write channel
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ADDR_W-1:0]      i_cfg_data,
    // input items
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [ADDR_W-1:0]      s_axis_tdata,  // store_address
    input  logic                   s_axis_tuser,  // opcode
    // result items
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // left_column, right_column, top_row, bottom_row, zero pad
    output logic [OUT_BYTES_W-1:0] m_axis_tdata,
    output logic [REGION_W-1:0]    m_axis_tuser   // region
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DIV  = 1'b1;

    logic                r_state, n_state;
    logic [ADDR_W-1:0]   r_base, r_limit;
    logic [DIM_W-1:0]    r_width, r_height;
    logic [DIM_W-1:0]    r_min_col, n_min_col, r_max_col, n_max_col;
    logic [DIM_W-1:0]    r_min_row, n_min_row, r_max_row, n_max_row;
    logic                r_m_valid, n_m_valid;
    logic [OUT_W-1:0]    r_m_data, n_m_data;
    logic [REGION_W-1:0] r_m_user, n_m_user;

    logic                in_accept;
    logic                cfg_accept;
    logic                div_start;
    logic [ADDR_W-1:0]   offset;
    t_div_result         div_res;
    logic                row_in;
    logic [DIM_W-1:0]    row, col;

    assign o_cfg_ready   = 1'b1;
    assign cfg_accept    = i_cfg_valid & o_cfg_ready;
    assign s_axis_tready = (r_state == ST_IDLE) && (!r_m_valid || m_axis_tready);
    assign in_accept     = s_axis_tvalid & s_axis_tready;

    // word offset from the display start
    assign offset = {2'b00, s_axis_tdata[ADDR_W-1:2]} - {2'b00, r_base[ADDR_W-1:2]};

    fdrt_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (offset),
        .i_divisor  (r_width),
        .o_result   (div_res)
    );

    assign row_in = (div_res.quotient < {{(ADDR_W-DIM_W){1'b0}}, r_height});
    assign row    = div_res.quotient[DIM_W-1:0];
    assign col    = div_res.remainder;

    // sequencer, rectangle update and output register
    always_comb begin
        n_state   = r_state;
        n_min_col = r_min_col;
        n_max_col = r_max_col;
        n_min_row = r_min_row;
        n_max_row = r_max_row;
        n_m_valid = r_m_valid;
        n_m_data  = r_m_data;
        n_m_user  = r_m_user;
        div_start = 1'b0;

        if (r_m_valid && m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    priority if (s_axis_tuser == OP_QUERY) begin
                        n_m_valid = 1'b1;
                        n_m_user  = REGION_QUERY;
                        n_m_data  = {r_max_row, r_min_row, r_max_col, r_min_col};
                        n_min_col = r_width;
                        n_max_col = '0;
                        n_min_row = r_height;
                        n_max_row = '0;
                    end else if (s_axis_tdata < r_base) begin
                        n_m_valid = 1'b1;
                        n_m_user  = REGION_RAM;
                        n_m_data  = {r_max_row, r_min_row, r_max_col, r_min_col};
                    end else if (s_axis_tdata < r_limit) begin
                        div_start = 1'b1;
                        n_state   = ST_DIV;
                    end else begin
                        n_m_valid = 1'b1;
                        n_m_user  = REGION_IO;
                        n_m_data  = {r_max_row, r_min_row, r_max_col, r_min_col};
                    end
                end
            end
            ST_DIV: begin
                if (div_res.done) begin
                    if (row_in) begin
                        if (col < r_min_col) n_min_col = col;
                        if (col > r_max_col) n_max_col = col;
                        if (row < r_min_row) n_min_row = row;
                        if (row > r_max_row) n_max_row = row;
                    end
                    n_m_valid = 1'b1;
                    n_m_user  = REGION_DISPLAY;
                    n_m_data  = {n_max_row, n_min_row, n_max_col, n_min_col};
                    n_state   = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_m_valid <= 1'b0;
            r_base    <= RST_DISPLAY_BASE;
            r_limit   <= RST_MEMORY_LIMIT;
            r_width   <= RST_FRAME_WIDTH;
            r_height  <= RST_FRAME_HEIGHT;
            r_min_col <= RST_FRAME_WIDTH;
            r_max_col <= '0;
            r_min_row <= RST_FRAME_HEIGHT;
            r_max_row <= '0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
            r_min_col <= n_min_col;
            r_max_col <= n_max_col;
            r_min_row <= n_min_row;
            r_max_row <= n_max_row;
            // register writes; the sender keeps them to times with nothing in flight
            if (cfg_accept) begin
                unique case (i_cfg_index)
                    CFG_DISPLAY_BASE: r_base   <= i_cfg_data;
                    CFG_MEMORY_LIMIT: r_limit  <= i_cfg_data;
                    CFG_FRAME_WIDTH:  r_width  <= clamp_dim(i_cfg_data[DIM_W-1:0]);
                    CFG_FRAME_HEIGHT: r_height <= clamp_dim(i_cfg_data[DIM_W-1:0]);
                    default: ;
                endcase
            end
        end
        r_m_data <= n_m_data;
        r_m_user <= n_m_user;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {{(OUT_BYTES_W-OUT_W){1'b0}}, r_m_data};
    assign m_axis_tuser  = r_m_user;

    // checks
    `ASSERT_SAME(a_done_in_div, i_clk, i_rst_n, div_res.done, r_state == ST_DIV, "divider done outside division")
    `ASSERT_SAME(a_out_empty_in_div, i_clk, i_rst_n, r_state == ST_DIV, !r_m_valid, "result pending during division")
    `ASSERT_NEXT(a_query_answer, i_clk, i_rst_n, in_accept && (s_axis_tuser == OP_QUERY), m_axis_tvalid && (m_axis_tuser == REGION_QUERY), "query gave no answer")
    `ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, div_start, r_state == ST_DIV && !s_axis_tready, "store accepted while dividing")

endmodule
